// File: rtl/tcp_syn_tracking_packet_filter_macros.svh
// tcp_syn_tracking_packet_filter_macros.svh
// Assertion macros used by the filter top level; no dependencies.
`ifndef TCP_SYN_TRACKING_PACKET_FILTER_MACROS_SVH
`define TCP_SYN_TRACKING_PACKET_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsf assertion failed");
`define TSF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tsf assertion failed");
`else
`define TSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TSF_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/tsf_pkg.sv
// tsf_pkg.sv
// Shared types and constants of the SYN-tracking filter; no dependencies.

package tsf_pkg;

    localparam int TableEntries = 256;

    localparam logic [15:0] TypeIpv4     = 16'h0800;
    localparam logic [7:0]  ProtoTcp     = 8'd6;
    localparam logic [15:0] EthIpv4Bytes = 16'd34;   // Ethernet plus minimum IPv4 header
    localparam logic [15:0] EthTcpBytes  = 16'd34;   // Ethernet plus minimum TCP header

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_key;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        CAT_OTHER          = 3'd0,
        CAT_NEW_SYN        = 3'd1,
        CAT_REPEAT_SYN     = 3'd2,
        CAT_KNOWN_SYNACK   = 3'd3,
        CAT_UNKNOWN_SYNACK = 3'd4,
        CAT_KNOWN_FLOW     = 3'd5,
        CAT_UNKNOWN_FLOW   = 3'd6
    } t_category;

endpackage

// File: rtl/tsf_cell.sv
// tsf_cell.sv
// One flow-key slot of the cell row: compare, insert, and shift-down on delete.
// Depends on tsf_pkg.

module tsf_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmp_en,
    input  tsf_pkg::t_key       i_cmp_key,
    input  tsf_pkg::t_key       i_ins_key,
    input  tsf_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_shift,
    input  logic                i_prev_valid,
    input  logic                i_next_valid,
    input  tsf_pkg::t_key       i_next_key,
    output logic                o_valid,
    output tsf_pkg::t_key       o_key,
    output logic                o_match
);

    logic          r_valid;
    logic          r_match;
    tsf_pkg::t_key r_key;
    logic          n_valid;
    logic          n_match;
    tsf_pkg::t_key n_key;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_match = r_match;
        if (i_cmp_en) begin
            n_match = r_valid && (r_key == i_cmp_key);
        end
        // Row stays packed: a delete pulls every slot at or above the hit down by one,
        // and an insert lands in the first empty slot.
        if (i_ctrl.del && i_shift) begin
            n_valid = i_next_valid;
            n_key   = i_next_key;
        end else if (i_ctrl.ins && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_key   = i_ins_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

// File: rtl/tsf_chain.sv
// tsf_chain.sv
// Row of tsf_cell slots holding the flow-key set, with hit and full detection.
// Depends on tsf_pkg and tsf_cell.

module tsf_chain (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmp_en,
    input  tsf_pkg::t_key                        i_cmp_key,
    input  tsf_pkg::t_key                        i_ins_key,
    input  tsf_pkg::t_cell_ctrl                  i_ctrl,
    output logic                                 o_found,
    output logic                                 o_full,
    output logic [tsf_pkg::TableEntries-1:0]     o_valid_vec
);

    logic [tsf_pkg::TableEntries-1:0] w_match;
    logic [tsf_pkg::TableEntries-1:0] w_valid;
    logic [tsf_pkg::TableEntries-1:0] w_shift;
    tsf_pkg::t_key                    w_key [tsf_pkg::TableEntries];

    // Match is one-hot; every slot at or above the hit takes part in the shift.
    assign w_shift = ~(w_match - tsf_pkg::TableEntries'(1));

    genvar g;
    generate
        for (g = 0; g < tsf_pkg::TableEntries; g++) begin : g_cell
            logic          w_prev_valid;
            logic          w_next_valid;
            tsf_pkg::t_key w_next_key;

            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[g-1];
            end

            if (g == tsf_pkg::TableEntries - 1) begin : g_last
                assign w_next_valid = 1'b0;
                assign w_next_key   = '0;
            end else begin : g_inner
                assign w_next_valid = w_valid[g+1];
                assign w_next_key   = w_key[g+1];
            end

            tsf_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmp_en     (i_cmp_en),
                .i_cmp_key    (i_cmp_key),
                .i_ins_key    (i_ins_key),
                .i_ctrl       (i_ctrl),
                .i_shift      (w_shift[g]),
                .i_prev_valid (w_prev_valid),
                .i_next_valid (w_next_valid),
                .i_next_key   (w_next_key),
                .o_valid      (w_valid[g]),
                .o_key        (w_key[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    assign o_found     = |w_match;
    assign o_full      = w_valid[tsf_pkg::TableEntries-1];
    assign o_valid_vec = w_valid;

endmodule

// File: rtl/tcp_syn_tracking_packet_filter.sv
// TCP SYN-tracking packet filter, top level.
// One request per parsed TCP/IPv4 header on the input channel (valid/ready), one
// result (verdict, category, insert_failed) per request on the output channel.
// Flow keys live in a packed row of 256 cells: valid slots fill the low end, so
// the first empty slot is found from neighbor valid bits and a delete pulls all
// higher slots down by one.
// An accepted request moves through the request, compare and output registers;
// no new request is taken while one sits in the request stage. The cell row
// compares the key in the request stage and inserts or deletes as the compare
// stage completes, and the next request compares only after that update.
// Reset clears every slot's valid bit at once; requests are taken from the first
// cycle after reset.
// When the receiver stalls, the result holds in the output register, the
// request behind it waits in the compare stage, and input ready drops.

`include "tcp_syn_tracking_packet_filter_macros.svh"

module tcp_syn_tracking_packet_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [3:0]  i_ip_header_words,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_verdict,
    output logic [2:0]  o_category,
    output logic        o_insert_failed
);

    typedef enum logic [1:0] {
        OP_PASS,
        OP_SYN,
        OP_SYNACK,
        OP_FLOW
    } t_op;

    logic                r_req_valid;
    logic                r_cmp_valid;
    logic                r_out_valid;
    t_op                 r_req_op;
    t_op                 r_cmp_op;
    tsf_pkg::t_key       r_req_key;
    tsf_pkg::t_key       r_cmp_key;
    logic                r_verdict;
    tsf_pkg::t_category  r_category;
    logic                r_insert_failed;

    logic                n_req_valid;
    logic                n_cmp_valid;
    logic                n_out_valid;
    t_op                 n_req_op;
    tsf_pkg::t_key       n_req_key;
    logic                n_verdict;
    tsf_pkg::t_category  n_category;
    logic                n_insert_failed;

    logic                w_out_free;
    logic                w_cmp_done;
    logic                w_accept;
    logic                w_not_tcp;
    logic [15:0]         w_min_len;
    logic                w_found;
    logic                w_full;
    tsf_pkg::t_cell_ctrl w_ctrl;
    logic [tsf_pkg::TableEntries-1:0] w_valid_vec;
    logic [tsf_pkg::TableEntries-1:0] w_valid_plus;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_cmp_done = r_cmp_valid && w_out_free;
    assign o_in_ready = !r_req_valid && (!r_cmp_valid || w_cmp_done);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_min_len = tsf_pkg::EthTcpBytes + {10'd0, i_ip_header_words, 2'b00};
    assign w_not_tcp = (i_ether_type != tsf_pkg::TypeIpv4)
                    || (i_frame_length < tsf_pkg::EthIpv4Bytes)
                    || (i_ip_protocol != tsf_pkg::ProtoTcp)
                    || (i_frame_length < w_min_len);

    always_comb begin
        n_req_key = '{src_addr: i_source_address, dst_addr: i_dest_address,
                      src_port: i_source_port, dst_port: i_dest_port};
        if (w_not_tcp) begin
            n_req_op = OP_PASS;
        end else if (i_syn_flag && !i_ack_flag) begin
            n_req_op = OP_SYN;
        end else if (i_syn_flag) begin
            n_req_op  = OP_SYNACK;
            // reply direction: look up the originating SYN's key
            n_req_key = '{src_addr: i_dest_address, dst_addr: i_source_address,
                          src_port: i_dest_port, dst_port: i_source_port};
        end else begin
            n_req_op = OP_FLOW;
        end
    end

    always_comb begin
        w_ctrl          = '{ins: 1'b0, del: 1'b0};
        n_verdict       = 1'b0;
        n_category      = tsf_pkg::CAT_OTHER;
        n_insert_failed = 1'b0;
        unique case (r_cmp_op)
            OP_PASS: begin
                n_verdict  = 1'b0;
                n_category = tsf_pkg::CAT_OTHER;
            end
            OP_SYN: begin
                if (w_found) begin
                    n_verdict  = 1'b1;
                    n_category = tsf_pkg::CAT_REPEAT_SYN;
                end else begin
                    n_category      = tsf_pkg::CAT_NEW_SYN;
                    n_insert_failed = w_full;
                    w_ctrl.ins      = w_cmp_done && !w_full;
                end
            end
            OP_SYNACK: begin
                n_verdict  = 1'b1;
                n_category = w_found ? tsf_pkg::CAT_KNOWN_SYNACK
                                     : tsf_pkg::CAT_UNKNOWN_SYNACK;
                w_ctrl.del = w_cmp_done && w_found;
            end
            OP_FLOW: begin
                n_verdict  = !w_found;
                n_category = w_found ? tsf_pkg::CAT_KNOWN_FLOW
                                     : tsf_pkg::CAT_UNKNOWN_FLOW;
            end
            default: begin
                n_verdict  = 1'b0;
                n_category = tsf_pkg::CAT_OTHER;
            end
        endcase
    end

    // The compare stage is always empty when the request stage advances.
    assign n_req_valid = w_accept;
    assign n_cmp_valid = r_req_valid || (r_cmp_valid && !w_out_free);
    assign n_out_valid = w_cmp_done || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_op  <= n_req_op;
            r_req_key <= n_req_key;
        end
        if (r_req_valid) begin
            r_cmp_op  <= r_req_op;
            r_cmp_key <= r_req_key;
        end
        if (w_cmp_done) begin
            r_verdict       <= n_verdict;
            r_category      <= n_category;
            r_insert_failed <= n_insert_failed;
        end
    end

    tsf_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmp_en    (r_req_valid),
        .i_cmp_key   (r_req_key),
        .i_ins_key   (r_cmp_key),
        .i_ctrl      (w_ctrl),
        .o_found     (w_found),
        .o_full      (w_full),
        .o_valid_vec (w_valid_vec)
    );

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_verdict;
    assign o_category      = r_category;
    assign o_insert_failed = r_insert_failed;

    assign w_valid_plus = w_valid_vec + tsf_pkg::TableEntries'(1);

    `TSF_ASSERT_NEVER(a_stage_overlap, i_clk, i_rst_n, r_req_valid && r_cmp_valid)
    `TSF_ASSERT_NEVER(a_row_packed, i_clk, i_rst_n, (w_valid_vec & w_valid_plus) != '0)
    `TSF_ASSERT_IMPLY(a_ins_has_room, i_clk, i_rst_n, w_ctrl.ins, !w_full && !w_found)
    `TSF_ASSERT_IMPLY(a_fail_is_new_syn, i_clk, i_rst_n, o_out_valid && o_insert_failed, o_category == tsf_pkg::CAT_NEW_SYN && $past(w_full))

endmodule
